// ===== design/tsr_pkg.sv =====
// Shared types and constants for the trail slot ring segment engine.
package tsr_pkg;

  localparam int ADDR_SLOTS = 16;
  localparam int ID_W       = 4;
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int THICK_W    = 12;
  localparam int GIVEN_W    = 5;
  localparam int QUOT_W     = 8;
  localparam logic [GIVEN_W-1:0] NO_FREE_ID = 5'd16;

  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_ADD    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_RENDER = 3'd4;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_ADD    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_RENDER = 3'd4
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic [THICK_W-1:0] thick;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [GIVEN_W-1:0] given;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic [THICK_W-1:0] thick;
    logic               last;
  } res_t;

endpackage

// ===== design/trail_slot_ring_segment_engine_top.sv =====
// Top level of the trail slot ring segment engine: stream ports and packing.
// Alloc: the reply goes through the emit state to the output register; free, add
// and clear complete in the back end's idle state. Render: a setup read of the head
// point, then per segment a point read, multiply, 8-step alpha divider and output register.
// A two-entry command queue lets input transfers continue during a render.
// Synchronous active-low reset clears slot flags, heads, fills and queues.
module trail_slot_ring_segment_engine_top import tsr_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int RING_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // trail_id[3:0], point_x[19:4], point_y[35:20], color_red[43:36],
  // color_green[51:44], color_blue[59:52], color_alpha[67:60],
  // line_thickness[79:68]
  input  logic [79:0]  in_tdata,
  // mode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // given_id[4:0], start_x[20:5], start_y[36:21], end_x[52:37], end_y[68:53],
  // seg_red[76:69], seg_green[84:77], seg_blue[92:85], seg_alpha[100:93],
  // seg_thickness[112:101], zeros[119:113]
  output logic [119:0] out_tdata,
  // result_kind[0]
  output logic         out_tuser,
  // last_segment
  output logic         out_tlast
);

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop;

  always_comb begin
    in_cmd.op    = OP_ALLOC;
    in_cmd.id    = in_tdata[3:0];
    in_cmd.px    = in_tdata[19:4];
    in_cmd.py    = in_tdata[35:20];
    in_cmd.red   = in_tdata[43:36];
    in_cmd.green = in_tdata[51:44];
    in_cmd.blue  = in_tdata[59:52];
    in_cmd.alpha = in_tdata[67:60];
    in_cmd.thick = in_tdata[79:68];
  end

  tsr_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tuser), .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop),
    .q_cmd(q_cmd)
  );

  tsr_back #(.SLOT_COUNT(SLOT_COUNT), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {7'd0, res.thick, res.alpha, res.blue, res.green, res.red,
                      res.ey, res.ex, res.sy, res.sx, res.given};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== design/tsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module tsr_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tsr_front.sv =====
// Command front end: decode, drop ignored commands, two-entry queue.
module tsr_front import tsr_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_mode,
  input  cmd_t            in_cmd,
  output logic            q_valid,
  input  logic            q_pop,
  output cmd_t            q_cmd
);

  localparam int LIVE = (SLOT_COUNT < ADDR_SLOTS) ? SLOT_COUNT : ADDR_SLOTS;

  cmd_t       ent_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep, push, id_ok;
  cmd_t       dec;

  always_comb begin
    id_ok = ({1'b0, in_cmd.id} < 5'(LIVE));
    dec   = in_cmd;
    keep  = 1'b1;
    unique case (in_mode)
      MODE_ALLOC:  dec.op = OP_ALLOC;
      MODE_FREE:   dec.op = OP_FREE;
      MODE_ADD:    dec.op = OP_ADD;
      MODE_CLEAR:  dec.op = OP_CLEAR;
      MODE_RENDER: dec.op = OP_RENDER;
      default: begin
        dec.op = OP_FREE;
        keep   = 1'b0;
      end
    endcase
    if (in_mode != MODE_ALLOC && !id_ok) begin
      keep = 1'b0;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = (q_pop && q_valid) ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= dec;
    end
  end

endmodule

// ===== design/tsr_back.sv =====
// Command back end: slot state, point ring, segment walk, alpha divider.
module tsr_back import tsr_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int RING_DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int LIVE   = (SLOT_COUNT < ADDR_SLOTS) ? SLOT_COUNT : ADDR_SLOTS;
  localparam int HEAD_W = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int DEN_W  = 2 * FILL_W;
  localparam int NUM_W  = DEN_W + QUOT_W;
  localparam int DEPTH  = ADDR_SLOTS * RING_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_LAT  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic              act_r  [ADDR_SLOTS];
  logic [HEAD_W-1:0] head_r [ADDR_SLOTS];
  logic [FILL_W-1:0] fill_r [ADDR_SLOTS];

  cmd_t                 cmd_r;
  logic                 render_r;
  logic [GIVEN_W-1:0]   given_r;
  logic [HEAD_W-1:0]    ptr_r;
  logic [FILL_W-1:0]    rem_seg_r;
  logic [DEN_W-1:0]     den_r, rr_r;
  logic [NUM_W-1:0]     num_r;
  logic [QUOT_W-1:0]    quo_r;
  logic [2:0]           bit_r;
  logic [COORD_W-1:0]   px_r, py_r, ex_r, ey_r;
  logic                 ov_r, ov_nxt;
  res_t                 ores_r, ores_nxt;

  logic                 we, re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [2*COORD_W-1:0] rdata;
  logic [HEAD_W-1:0]    head_new, ptr_dec;
  logic [GIVEN_W-1:0]   free_id;
  logic [NUM_W-1:0]     shifted;
  logic                 out_free;
  logic [ID_W-1:0]      sid;

  tsr_ram #(.DATA_W(2 * COORD_W), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata({q_cmd.py, q_cmd.px}),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ID_W-1:0] s,
                                                   input logic [HEAD_W-1:0] idx);
    slot_addr = ADDR_W'(s) * ADDR_W'(RING_DEPTH) + ADDR_W'(idx);
  endfunction

  always_comb begin
    free_id = NO_FREE_ID;
    for (int s = LIVE - 1; s >= 0; s--) begin
      if (!act_r[s]) begin
        free_id = GIVEN_W'(s);
      end
    end
  end

  assign sid      = q_cmd.id;
  assign head_new = (head_r[sid] == HEAD_MAX) ? '0 : head_r[sid] + 1'b1;
  assign ptr_dec  = (ptr_r == '0) ? HEAD_MAX : ptr_r - 1'b1;
  assign out_free = !ov_r || out_ready;
  assign shifted  = NUM_W'(den_r) << bit_r;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    we        = 1'b0;
    waddr     = slot_addr(sid, head_new);
    re        = 1'b0;
    raddr     = slot_addr(sid, head_r[sid]);
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_ALLOC:  state_nxt = S_EMIT;
            OP_ADD:    we = act_r[sid];
            OP_RENDER: begin
              if (act_r[sid] && fill_r[sid] >= FILL_W'(2)) begin
                re        = 1'b1;
                state_nxt = S_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        re        = 1'b1;
        raddr     = slot_addr(cmd_r.id, ptr_dec);
        state_nxt = S_LAT;
      end
      S_LAT: state_nxt = S_MUL;
      S_MUL: state_nxt = S_DIV;
      S_DIV: if (bit_r == 3'd0) state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (render_r && rem_seg_r != FILL_W'(1)) begin
            re        = 1'b1;
            raddr     = slot_addr(cmd_r.id, ptr_dec);
            state_nxt = S_LAT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt   = ov_r;
    ores_nxt = ores_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (state_r == S_EMIT && out_free) begin
      ov_nxt   = 1'b1;
      ores_nxt = '0;
      if (render_r) begin
        ores_nxt.kind  = 1'b1;
        ores_nxt.sx    = px_r;
        ores_nxt.sy    = py_r;
        ores_nxt.ex    = ex_r;
        ores_nxt.ey    = ey_r;
        ores_nxt.red   = cmd_r.red;
        ores_nxt.green = cmd_r.green;
        ores_nxt.blue  = cmd_r.blue;
        ores_nxt.alpha = quo_r;
        ores_nxt.thick = cmd_r.thick;
        ores_nxt.last  = (rem_seg_r == FILL_W'(1));
      end else begin
        ores_nxt.given = given_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int s = 0; s < ADDR_SLOTS; s++) begin
        act_r[s]  <= 1'b0;
        head_r[s] <= '0;
        fill_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (state_r == S_IDLE && q_valid) begin
        unique case (q_cmd.op)
          OP_ALLOC: begin
            if (free_id != NO_FREE_ID) begin
              act_r[free_id[ID_W-1:0]]  <= 1'b1;
              head_r[free_id[ID_W-1:0]] <= '0;
              fill_r[free_id[ID_W-1:0]] <= '0;
            end
          end
          OP_FREE: begin
            act_r[sid]  <= 1'b0;
            head_r[sid] <= '0;
            fill_r[sid] <= '0;
          end
          OP_ADD: begin
            if (act_r[sid]) begin
              head_r[sid] <= head_new;
              if (fill_r[sid] != FILL_MAX) begin
                fill_r[sid] <= fill_r[sid] + 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            head_r[sid] <= '0;
            fill_r[sid] <= '0;
          end
          default: ;
        endcase
      end
    end

    ores_r <= ores_nxt;

    unique case (state_r)
      S_IDLE: begin
        cmd_r     <= q_cmd;
        given_r   <= free_id;
        render_r  <= (q_cmd.op == OP_RENDER);
        ptr_r     <= head_r[sid];
        rem_seg_r <= fill_r[sid] - 1'b1;
      end
      S_PREP: begin
        px_r  <= rdata[COORD_W-1:0];
        py_r  <= rdata[2*COORD_W-1:COORD_W];
        den_r <= DEN_W'(rem_seg_r) * DEN_W'(rem_seg_r);
        ptr_r <= ptr_dec;
      end
      S_LAT: begin
        ex_r <= rdata[COORD_W-1:0];
        ey_r <= rdata[2*COORD_W-1:COORD_W];
        rr_r <= DEN_W'(rem_seg_r) * DEN_W'(rem_seg_r);
      end
      S_MUL: begin
        num_r <= NUM_W'(cmd_r.alpha) * NUM_W'(rr_r);
        quo_r <= '0;
        bit_r <= 3'd7;
      end
      S_DIV: begin
        if (num_r >= shifted) begin
          num_r        <= num_r - shifted;
          quo_r[bit_r] <= 1'b1;
        end
        bit_r <= bit_r - 1'b1;
      end
      S_EMIT: begin
        if (out_free && render_r) begin
          px_r      <= ex_r;
          py_r      <= ey_r;
          rem_seg_r <= rem_seg_r - 1'b1;
          ptr_r     <= ptr_dec;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_res   = ores_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the trail slot ring segment engine.
module tb import tsr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int DEPTH = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  trail_slot_ring_segment_engine_top #(.SLOT_COUNT(SLOTS), .RING_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  bit          trail_live [SLOTS];
  logic [4:0]  trail_head [SLOTS];
  logic [5:0]  trail_fill [SLOTS];
  logic [15:0] trail_px [SLOTS][DEPTH];
  logic [15:0] trail_py [SLOTS][DEPTH];

  res_t segment_queue[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  function automatic void predict_command(cmd_t c);
    res_t r;
    int unsigned n, span, den, h, i1, i2, a, rr;
    if (c.op == OP_ALLOC) begin
      r = '0;
      r.given = NO_FREE_ID;
      for (int s = 0; s < SLOTS; s++) begin
        if (!trail_live[s]) begin
          trail_live[s] = 1'b1;
          trail_head[s] = '0;
          trail_fill[s] = '0;
          r.given = s[4:0];
          break;
        end
      end
      segment_queue.push_back(r);
      return;
    end
    if (int'(c.id) >= SLOTS) return;
    case (c.op)
      OP_FREE: begin
        trail_live[c.id] = 1'b0;
        trail_head[c.id] = '0;
        trail_fill[c.id] = '0;
      end
      OP_ADD: begin
        if (trail_live[c.id]) begin
          h = (32'(trail_head[c.id]) + 1) % DEPTH;
          trail_head[c.id] = h[4:0];
          trail_px[c.id][h] = c.px;
          trail_py[c.id][h] = c.py;
          if (trail_fill[c.id] < DEPTH) trail_fill[c.id] = trail_fill[c.id] + 6'd1;
        end
      end
      OP_CLEAR: begin
        trail_head[c.id] = '0;
        trail_fill[c.id] = '0;
      end
      OP_RENDER: begin
        n = 32'(trail_fill[c.id]);
        if (trail_live[c.id] && n >= 2) begin
          span = n - 1;
          den = span * span;
          h = 32'(trail_head[c.id]);
          a = 32'(c.alpha);
          for (int unsigned i = 0; i < span; i++) begin
            i1 = (h + DEPTH - i) % DEPTH;
            i2 = (h + 2 * DEPTH - (i + 1)) % DEPTH;
            rr = span - i;
            r = '0;
            r.kind = 1'b1;
            r.sx = trail_px[c.id][i1];
            r.sy = trail_py[c.id][i1];
            r.ex = trail_px[c.id][i2];
            r.ey = trail_py[c.id][i2];
            r.red = c.red;
            r.green = c.green;
            r.blue = c.blue;
            r.alpha = 8'((a * rr * rr) / den);
            r.thick = c.thick;
            r.last = (i + 1 == span);
            segment_queue.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(logic [2:0] mode, logic [3:0] id, logic [15:0] px,
                              logic [15:0] py, logic [31:0] rgba, logic [11:0] thick);
    cmd_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    c.op = op_t'(mode);
    c.id = id; c.px = px; c.py = py;
    c.red = rgba[7:0]; c.green = rgba[15:8]; c.blue = rgba[23:16]; c.alpha = rgba[31:24];
    c.thick = thick;
    in_tuser <= mode;
    in_tdata <= {thick, c.alpha, c.blue, c.green, c.red, py, px, id};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(c);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.last = out_tlast;
      {got.thick, got.alpha, got.blue, got.green, got.red, got.ey, got.ex,
       got.sy, got.sx, got.given} = out_tdata[112:0];
      if (segment_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = segment_queue.pop_front();
        if (got !== exp_r || out_tdata[119:113] !== '0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", exp_r, got);
        end
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (segment_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_directed();
    send_command(MODE_RENDER, 4'd0, '0, '0, '1, '1);
    send_command(MODE_ADD, 4'd0, 16'h1234, 16'h4321, '0, '0);
    send_command(MODE_ALLOC, 4'd0, '0, '0, '0, '0);
    send_command(MODE_ADD, 4'd0, 16'h8000, 16'h7fff, '0, '0);
    send_command(MODE_RENDER, 4'd0, '0, '0, 32'hffffffff, 12'hfff);
    send_command(MODE_ADD, 4'd0, 16'h7fff, 16'h8000, '0, '0);
    send_command(MODE_ADD, 4'd0, 16'hffff, 16'h0000, '0, '0);
    send_command(MODE_RENDER, 4'd0, '0, '0, 32'hff00ff00, 12'h0ff);
    send_command(MODE_RENDER, 4'd0, '0, '0, 32'h00ff00ff, 12'h000);
    send_command(MODE_CLEAR, 4'd0, '0, '0, '0, '0);
    send_command(MODE_RENDER, 4'd0, '0, '0, '1, '1);
    send_command(MODE_CLEAR, 4'd9, '0, '0, '0, '0);
    send_command(3'd5, 4'd0, '0, '0, '0, '0);
    send_command(3'd7, 4'd15, '1, '1, '1, '1);
    for (int k = 0; k < 40; k++)
      send_command(MODE_ADD, 4'd0, 16'($urandom), 16'($urandom), '0, '0);
    send_command(MODE_RENDER, 4'd0, '0, '0, 32'hffffffff, 12'habc);
    send_command(MODE_FREE, 4'd0, '0, '0, '0, '0);
    send_command(MODE_RENDER, 4'd0, '0, '0, '1, '1);
    for (int k = 0; k < 17; k++) send_command(MODE_ALLOC, '0, '0, '0, '0, '0);
    send_command(MODE_FREE, 4'd15, '0, '0, '0, '0);
    send_command(MODE_ALLOC, '0, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(int items);
    int unsigned pick;
    logic [3:0] id;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      id = 4'($urandom_range(15));
      if (pick < 8)       send_command(MODE_ALLOC, 4'($urandom), '0, '0, '0, '0);
      else if (pick < 13) send_command(MODE_FREE, id, '0, '0, '0, '0);
      else if (pick < 65) send_command(MODE_ADD, id, rand_coord(), rand_coord(),
                                       $urandom, 12'($urandom));
      else if (pick < 70) send_command(MODE_CLEAR, id, '0, '0, '0, '0);
      else if (pick < 97) send_command(MODE_RENDER, id, 16'($urandom), 16'($urandom),
                                       $urandom, 12'($urandom));
      else                send_command(3'($urandom_range(7, 5)), id, 16'($urandom),
                                       16'($urandom), $urandom, 12'($urandom));
    end
    drain();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      trail_live[s] = 1'b0;
      trail_head[s] = '0;
      trail_fill[s] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(58);
    send_idle_pct = 55; recv_stall_pct = 0;  test_random(58);
    send_idle_pct = 0;  recv_stall_pct = 55; test_random(58);
    send_idle_pct = 13; recv_stall_pct = 13; test_random(58);
    if (mismatches == 0 && segment_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
